FILE: sv/assert_macros.svh
// Assertion macros used by the allocator core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) `ASSERT_CLK(lbl, clk, rstn, !(cond))

`endif

FILE: sv/bpfa_pkg.sv
// Types and constants of the bitmap page frame allocator
package bpfa_pkg;

  localparam int FRAME_COUNT_DEF = 32768;
  localparam int PAGE_BYTES_DEF  = 4096;
  localparam int WORD_BITS       = 32;
  localparam int BIT_IDX_W       = 5;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int ADDR_W   = 32;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_DATA_W-1:0] KERNEL_END_RST = 32'h0000_0000;
  localparam logic [CFG_DATA_W-1:0] LOW_LIMIT_RST  = 32'h0010_0000;

  typedef enum logic [CMD_W-1:0] {
    CMD_REGION  = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_OOM   = 2'd1,
    ST_NOCHG = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_END = 1'b0,
    REG_LOW_LIMIT  = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_PREP,
    S_RGN_RD,
    S_RGN_WR,
    S_SCAN,
    S_REL_RD,
    S_REL_WR,
    S_DONE
  } state_e;

endpackage

FILE: sv/bpfa_if.sv
// Command and response channel interfaces of the allocator
interface bpfa_cmd_if;
  import bpfa_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [ADDR_W-1:0]   region_base;
  logic [ADDR_W-1:0]   region_length;
  logic                region_available;
  logic [ADDR_W-1:0]   release_address;

  modport source (
    output valid, command, region_base, region_length, region_available, release_address,
    input  ready
  );
  modport sink (
    input  valid, command, region_base, region_length, region_available, release_address,
    output ready
  );
endinterface

interface bpfa_rsp_if;
  import bpfa_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   page_address;
  logic [ADDR_W-1:0]   total_bytes;
  logic [ADDR_W-1:0]   free_bytes;

  modport source (
    output valid, status, page_address, total_bytes, free_bytes,
    input  ready
  );
  modport sink (
    input  valid, status, page_address, total_bytes, free_bytes,
    output ready
  );
endinterface

FILE: sv/bitmap_page_frame_allocator_core.sv
// Bitmap page frame allocator: used map in RAM, 32 frames per word, plus page counters
// Alloc reads one map word a cycle until a clear bit is found or the last word is checked;
// region reads and writes back each map word it touches; release reads one word and clears
// the bit if set. One command at a time; the next is taken while the previous response waits.
// Reset: async, active low; an init pass then sets each of the MAP_WORDS (1024 by default)
// map words to all used, during which no command is taken (config writes still are).
`include "assert_macros.svh"

module bitmap_page_frame_allocator_core #(
  parameter int FRAME_COUNT = bpfa_pkg::FRAME_COUNT_DEF,
  parameter int PAGE_BYTES  = bpfa_pkg::PAGE_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bpfa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bpfa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  bpfa_cmd_if.sink                       cmd,
  bpfa_rsp_if.source                     rsp
);
  import bpfa_pkg::*;

  localparam int MAP_WORDS = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PG_SHIFT  = $clog2(PAGE_BYTES);
  localparam int PW_A      = 33 - PG_SHIFT;
  localparam int PW_B      = AW + BIT_IDX_W + 1;
  localparam int PW        = (PW_A > PW_B) ? PW_A : PW_B;
  localparam int PA_W      = AW + BIT_IDX_W + PG_SHIFT;

  localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);
  localparam logic [PW-1:0] FRAMES    = PW'(FRAME_COUNT);

  state_e state_q, state_d;

  logic [ADDR_W-1:0] kernel_q, kernel_d;
  logic [ADDR_W-1:0] low_q, low_d;
  logic [ADDR_W-1:0] avail_q, avail_d;
  logic [ADDR_W-1:0] used_q, used_d;

  logic [AW-1:0] init_q, init_d;
  logic [AW-1:0] scan_q, scan_d;
  logic [AW-1:0] chk_q, chk_d;
  logic          pend_q, pend_d;
  logic          issued_q, issued_d;

  logic [PW-1:0] first_q, first_d, end_q, end_d, lowc_q, lowc_d, kerc_q, kerc_d;
  logic [AW-1:0] w_q, w_d, sw_q, sw_d, ew_q, ew_d;
  logic [BIT_IDX_W-1:0] lo0_q, lo0_d, hi0_q, hi0_d;
  logic [AW-1:0] rel_word_q, rel_word_d;
  logic [BIT_IDX_W-1:0] rel_bit_q, rel_bit_d;

  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [ADDR_W-1:0]   res_page_q, res_page_d;

  logic                rsp_valid_q, rsp_valid_d;
  logic [STATUS_W-1:0] rsp_status_q, rsp_status_d;
  logic [ADDR_W-1:0]   rsp_page_q, rsp_page_d;
  logic [ADDR_W-1:0]   rsp_total_q, rsp_total_d;
  logic [ADDR_W-1:0]   rsp_free_q, rsp_free_d;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  logic [ADDR_W-1:0]    first_sum, end_sum;
  logic [ADDR_W:0]      low_sum, ker_sum;
  logic [PW-1:0]        rel_page, start_pg, endc_pg, last_pg;
  logic                 rel_in_range, rsp_free;
  logic [WORD_BITS-1:0] zero_oh, rgn_mask;
  logic [BIT_IDX_W-1:0] zero_idx, lo_bit, hi_bit;
  logic                 word_full;
  logic [PA_W-1:0]      pa_full;

  bpfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // page range arithmetic
  assign first_sum    = cmd.region_base + ADDR_W'(PAGE_BYTES - 1);
  assign end_sum      = cmd.region_base + cmd.region_length;
  assign low_sum      = {1'b0, low_q} + (ADDR_W + 1)'(PAGE_BYTES - 1);
  assign ker_sum      = {1'b0, kernel_q} + (ADDR_W + 1)'(PAGE_BYTES - 1);
  assign rel_page     = PW'(cmd.release_address >> PG_SHIFT);
  assign rel_in_range = rel_page < FRAMES;

  always_comb begin
    start_pg = first_q;
    if (lowc_q > start_pg) begin
      start_pg = lowc_q;
    end
    if (kerc_q > start_pg) begin
      start_pg = kerc_q;
    end
    endc_pg = (end_q > FRAMES) ? FRAMES : end_q;
    last_pg = endc_pg - PW'(1);
  end

  assign lo_bit   = (w_q == sw_q) ? lo0_q : '0;
  assign hi_bit   = (w_q == ew_q) ? hi0_q : BIT_IDX_W'(WORD_BITS - 1);
  assign rgn_mask = ({WORD_BITS{1'b1}} << lo_bit) &
                    ({WORD_BITS{1'b1}} >> (BIT_IDX_W'(WORD_BITS - 1) - hi_bit));

  // lowest clear bit of the word just read
  assign word_full = &ram_rdata;
  assign zero_oh   = ~ram_rdata & (ram_rdata + WORD_BITS'(1));
  always_comb begin
    zero_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (zero_oh[i]) begin
        zero_idx = zero_idx | BIT_IDX_W'(i);
      end
    end
  end
  assign pa_full = {chk_q, zero_idx, {PG_SHIFT{1'b0}}};

  assign rsp_free = !rsp_valid_q || rsp.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT: begin
        if (init_q == LAST_WORD) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (cmd.valid) begin
          case (cmd.command)
            CMD_REGION:  state_d = cmd.region_available ? S_PREP : S_DONE;
            CMD_ALLOC:   state_d = S_SCAN;
            CMD_RELEASE: state_d = rel_in_range ? S_REL_RD : S_DONE;
            default:     state_d = S_DONE;
          endcase
        end
      end
      S_PREP:   state_d = (endc_pg > start_pg) ? S_RGN_RD : S_DONE;
      S_RGN_RD: state_d = S_RGN_WR;
      S_RGN_WR: state_d = (w_q == ew_q) ? S_DONE : S_RGN_RD;
      S_SCAN: begin
        if (pend_q && (!word_full || chk_q == LAST_WORD)) state_d = S_DONE;
      end
      S_REL_RD: state_d = S_REL_WR;
      S_REL_WR: state_d = S_DONE;
      S_DONE: begin
        if (rsp_free) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    kernel_d     = kernel_q;
    low_d        = low_q;
    avail_d      = avail_q;
    used_d       = used_q;
    init_d       = init_q;
    scan_d       = scan_q;
    chk_d        = chk_q;
    pend_d       = 1'b0;
    issued_d     = issued_q;
    first_d      = first_q;
    end_d        = end_q;
    lowc_d       = lowc_q;
    kerc_d       = kerc_q;
    w_d          = w_q;
    sw_d         = sw_q;
    ew_d         = ew_q;
    lo0_d        = lo0_q;
    hi0_d        = hi0_q;
    rel_word_d   = rel_word_q;
    rel_bit_d    = rel_bit_q;
    res_status_d = res_status_q;
    res_page_d   = res_page_q;
    rsp_valid_d  = rsp_valid_q && !rsp.ready;
    rsp_status_d = rsp_status_q;
    rsp_page_d   = rsp_page_q;
    rsp_total_d  = rsp_total_q;
    rsp_free_d   = rsp_free_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = w_q;
    ram_raddr    = w_q;
    ram_wdata    = ram_rdata;

    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_KERNEL_END: kernel_d = cfg_data_i;
        REG_LOW_LIMIT:  low_d    = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = init_q;
        ram_wdata = '1;
        init_d    = init_q + AW'(1);
      end
      S_IDLE: begin
        if (cmd.valid) begin
          res_status_d = ST_NOCHG;
          res_page_d   = '0;
          first_d      = PW'(first_sum >> PG_SHIFT);
          end_d        = PW'(end_sum >> PG_SHIFT);
          lowc_d       = PW'(low_sum >> PG_SHIFT);
          kerc_d       = PW'(ker_sum >> PG_SHIFT);
          scan_d       = '0;
          issued_d     = 1'b0;
          rel_word_d   = rel_page[AW+BIT_IDX_W-1:BIT_IDX_W];
          rel_bit_d    = rel_page[BIT_IDX_W-1:0];
        end
      end
      S_PREP: begin
        if (endc_pg > start_pg) begin
          avail_d      = avail_q + ADDR_W'(endc_pg - start_pg);
          res_status_d = ST_DONE;
          w_d          = start_pg[AW+BIT_IDX_W-1:BIT_IDX_W];
          sw_d         = start_pg[AW+BIT_IDX_W-1:BIT_IDX_W];
          lo0_d        = start_pg[BIT_IDX_W-1:0];
          ew_d         = last_pg[AW+BIT_IDX_W-1:BIT_IDX_W];
          hi0_d        = last_pg[BIT_IDX_W-1:0];
        end
      end
      S_RGN_RD: begin
        ram_re = 1'b1;
      end
      S_RGN_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata & ~rgn_mask;
        w_d       = w_q + AW'(1);
      end
      S_SCAN: begin
        if (pend_q && !word_full) begin
          ram_we       = 1'b1;
          ram_waddr    = chk_q;
          ram_wdata    = ram_rdata | zero_oh;
          used_d       = used_q + ADDR_W'(1);
          res_status_d = ST_DONE;
          res_page_d   = ADDR_W'(pa_full);
        end else begin
          if (pend_q && chk_q == LAST_WORD) begin
            res_status_d = ST_OOM;
          end
          if (!issued_q) begin
            ram_re    = 1'b1;
            ram_raddr = scan_q;
            chk_d     = scan_q;
            pend_d    = 1'b1;
            if (scan_q == LAST_WORD) begin
              issued_d = 1'b1;
            end else begin
              scan_d = scan_q + AW'(1);
            end
          end
        end
      end
      S_REL_RD: begin
        ram_re    = 1'b1;
        ram_raddr = rel_word_q;
      end
      S_REL_WR: begin
        if (ram_rdata[rel_bit_q]) begin
          ram_we       = 1'b1;
          ram_waddr    = rel_word_q;
          ram_wdata    = ram_rdata & ~(WORD_BITS'(1) << rel_bit_q);
          used_d       = used_q - ADDR_W'(1);
          res_status_d = ST_DONE;
        end
      end
      S_DONE: begin
        if (rsp_free) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = res_status_q;
          rsp_page_d   = res_page_q;
          rsp_total_d  = avail_q << PG_SHIFT;
          rsp_free_d   = (avail_q - used_q) << PG_SHIFT;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      kernel_q    <= KERNEL_END_RST;
      low_q       <= LOW_LIMIT_RST;
      avail_q     <= '0;
      used_q      <= '0;
      init_q      <= '0;
      pend_q      <= 1'b0;
      issued_q    <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kernel_q    <= kernel_d;
      low_q       <= low_d;
      avail_q     <= avail_d;
      used_q      <= used_d;
      init_q      <= init_d;
      pend_q      <= pend_d;
      issued_q    <= issued_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q       <= scan_d;
    chk_q        <= chk_d;
    first_q      <= first_d;
    end_q        <= end_d;
    lowc_q       <= lowc_d;
    kerc_q       <= kerc_d;
    w_q          <= w_d;
    sw_q         <= sw_d;
    ew_q         <= ew_d;
    lo0_q        <= lo0_d;
    hi0_q        <= hi0_d;
    rel_word_q   <= rel_word_d;
    rel_bit_q    <= rel_bit_d;
    res_status_q <= res_status_d;
    res_page_q   <= res_page_d;
    rsp_status_q <= rsp_status_d;
    rsp_page_q   <= rsp_page_d;
    rsp_total_q  <= rsp_total_d;
    rsp_free_q   <= rsp_free_d;
  end

  assign cmd.ready        = (state_q == S_IDLE);
  assign rsp.valid        = rsp_valid_q;
  assign rsp.status       = rsp_status_q;
  assign rsp.page_address = rsp_page_q;
  assign rsp.total_bytes  = rsp_total_q;
  assign rsp.free_bytes   = rsp_free_q;

  `ASSERT_CLK(a_alloc_sets_one, clk_i, rst_ni, (state_q == S_SCAN && ram_we) |-> ($countones(ram_wdata) == $countones(ram_rdata) + 1))
  `ASSERT_NEVER(a_region_only_clears, clk_i, rst_ni, state_q == S_RGN_WR && ((ram_wdata & ~ram_rdata) != '0))
  `ASSERT_CLK(a_accept_leaves_idle, clk_i, rst_ni, (cmd.valid && cmd.ready) |=> (state_q != S_IDLE && state_q != S_INIT))

endmodule

FILE: sv/bpfa_ram.sv
// Generic simple dual-port RAM with registered read
module bpfa_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench of the bitmap page frame allocator core
`timescale 1ns / 1ps

module testbench;
  import bpfa_pkg::*;

  localparam logic [31:0] FRAMES    = FRAME_COUNT_DEF;
  localparam logic [31:0] PAGE_SZ   = PAGE_BYTES_DEF;
  localparam int          MAP_WORDS = FRAME_COUNT_DEF / WORD_BITS;

  localparam logic [CMD_W-1:0] CMD_RSVD = 2'd3;

  localparam int SETTLE_CYCLES   = 8;
  localparam int QUIET_LIMIT     = 20000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_AFTER      = 40;
  localparam int RANDOM_BATCHES  = 7;
  localparam int BATCH_WORDS     = 80;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] region_base;
    logic [ADDR_W-1:0] region_length;
    logic              region_available;
    logic [ADDR_W-1:0] release_address;
  } frame_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   page_address;
    logic [ADDR_W-1:0]   total_bytes;
    logic [ADDR_W-1:0]   free_bytes;
  } frame_rsp_t;

  typedef struct packed {
    bit                    is_cfg;
    cfg_reg_e              reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    frame_op_t             op;
    bit                    typed;
    frame_rsp_t            rsp;
  } step_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  bpfa_cmd_if cmd_ch ();
  bpfa_rsp_if rsp_ch ();

  bitmap_page_frame_allocator_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd        (cmd_ch),
    .rsp        (rsp_ch)
  );

  // allocator image: used bits, page counters, reserved limits
  logic [WORD_BITS-1:0] used_words [MAP_WORDS];
  logic [31:0]          avail_pages;
  logic [31:0]          used_pages;
  logic [31:0]          kern_limit;
  logic [31:0]          low_limit;
  logic [31:0]          handed_out [$];

  frame_rsp_t replies_due [$];
  int         replies_seen = 0;
  int         mismatches   = 0;
  int         quiet_cycles = 0;
  int         burst_left   = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < 50)
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  function automatic frame_rsp_t apply_frame_op(frame_op_t op);
    frame_rsp_t  r;
    logic [31:0] first_pg, end_pg, pg, frame;
    int          w, b;
    r.status       = ST_NOCHG;
    r.page_address = '0;
    frame          = '0;
    case (op.command)
      CMD_REGION: begin
        if (op.region_available) begin
          first_pg = (op.region_base + (PAGE_SZ - 32'd1)) / PAGE_SZ;
          end_pg   = (op.region_base + op.region_length) / PAGE_SZ;
          if (end_pg > FRAMES) end_pg = FRAMES;
          for (pg = first_pg; pg < end_pg; pg++) begin
            if (pg * PAGE_SZ >= low_limit && pg * PAGE_SZ >= kern_limit) begin
              used_words[pg >> BIT_IDX_W][pg[BIT_IDX_W-1:0]] = 1'b0;
              avail_pages++;
              r.status = ST_DONE;
            end
          end
        end
      end
      CMD_ALLOC: begin
        r.status = ST_OOM;
        for (w = 0; w < MAP_WORDS && r.status == ST_OOM; w++) begin
          for (b = 0; b < WORD_BITS; b++) begin
            if (!used_words[w][b] && r.status == ST_OOM) begin
              r.status = ST_DONE;
              frame    = w * WORD_BITS + b;
            end
          end
        end
        if (r.status == ST_DONE) begin
          used_words[frame >> BIT_IDX_W][frame[BIT_IDX_W-1:0]] = 1'b1;
          used_pages++;
          r.page_address = frame * PAGE_SZ;
          handed_out.push_back(r.page_address);
        end
      end
      CMD_RELEASE: begin
        frame = op.release_address / PAGE_SZ;
        if (frame < FRAMES && used_words[frame >> BIT_IDX_W][frame[BIT_IDX_W-1:0]]) begin
          used_words[frame >> BIT_IDX_W][frame[BIT_IDX_W-1:0]] = 1'b0;
          used_pages--;
          r.status = ST_DONE;
        end
      end
      default: ;
    endcase
    r.total_bytes = avail_pages * PAGE_SZ;
    r.free_bytes  = (avail_pages - used_pages) * PAGE_SZ;
    return r;
  endfunction

  function automatic frame_op_t random_frame_op();
    frame_op_t op;
    int        pick, slot;
    op.command          = CMD_REGION;
    op.region_base      = $urandom;
    op.region_length    = $urandom;
    op.region_available = 1'($urandom_range(0, 1));
    op.release_address  = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        op.region_base = $urandom_range(0, FRAME_COUNT_DEF - 1) * PAGE_SZ
                       + ($urandom_range(0, 1) ? 0 : $urandom_range(0, PAGE_BYTES_DEF - 1));
        op.region_length = $urandom_range(1, 64) * PAGE_SZ
                         + ($urandom_range(0, 3) == 0 ? $urandom_range(0, PAGE_BYTES_DEF - 1) : 0);
        op.region_available = ($urandom_range(0, 9) != 0);
      end else if (pick < 84) begin
        op.region_base      = $urandom_range(0, FRAME_COUNT_DEF - 1) * PAGE_SZ;
        op.region_available = 1'b1;
      end
    end else if (pick < 65) begin
      op.command = CMD_ALLOC;
    end else if (pick < 95) begin
      op.command = CMD_RELEASE;
      pick = $urandom_range(0, 99);
      if (pick < 60 && handed_out.size() > 0) begin
        slot = $urandom_range(0, handed_out.size() - 1);
        op.release_address = handed_out[slot] + $urandom_range(0, PAGE_BYTES_DEF - 1);
        handed_out.delete(slot);
      end else if (pick < 85) begin
        op.release_address = $urandom_range(0, FRAME_COUNT_DEF * PAGE_BYTES_DEF - 1);
      end
    end else begin
      op.command = CMD_RSVD;
    end
    return op;
  endfunction

  function automatic step_t op_row(logic [CMD_W-1:0] c, logic [ADDR_W-1:0] base,
                                   logic [ADDR_W-1:0] len, logic avail,
                                   logic [ADDR_W-1:0] rel);
    step_t s;
    s = '0;
    s.op.command          = c;
    s.op.region_base      = base;
    s.op.region_length    = len;
    s.op.region_available = avail;
    s.op.release_address  = rel;
    return s;
  endfunction

  function automatic step_t fixed_row(step_t s, logic [STATUS_W-1:0] st,
                                      logic [ADDR_W-1:0] pg, logic [ADDR_W-1:0] tot,
                                      logic [ADDR_W-1:0] fr);
    s.typed            = 1'b1;
    s.rsp.status       = st;
    s.rsp.page_address = pg;
    s.rsp.total_bytes  = tot;
    s.rsp.free_bytes   = fr;
    return s;
  endfunction

  function automatic step_t cfg_row(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    step_t s;
    s = '0;
    s.is_cfg  = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  task automatic send_op(frame_op_t op, bit typed, frame_rsp_t fixed);
    frame_rsp_t want;
    int         gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        cmd_ch.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    cmd_ch.valid            <= 1'b1;
    cmd_ch.command          <= op.command;
    cmd_ch.region_base      <= op.region_base;
    cmd_ch.region_length    <= op.region_length;
    cmd_ch.region_available <= op.region_available;
    cmd_ch.release_address  <= op.release_address;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    want = apply_frame_op(op);
    replies_due.push_back(typed ? fixed : want);
  endtask

  // block is idle once every reply is in
  task automatic settle();
    @(negedge clk_i);
    cmd_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == REG_KERNEL_END) kern_limit = val;
    else low_limit = val;
  endtask

  initial begin : stimulus
    step_t       plan [$];
    logic [31:0] kend_val, low_val;
    int          b;
    cmd_ch.valid            = 1'b0;
    cmd_ch.command          = CMD_REGION;
    cmd_ch.region_base      = '0;
    cmd_ch.region_length    = '0;
    cmd_ch.region_available = 1'b0;
    cmd_ch.release_address  = '0;
    cfg_we_i                = 1'b0;
    cfg_idx_i               = REG_KERNEL_END;
    cfg_data_i              = '0;
    foreach (used_words[i]) used_words[i] = '1;
    avail_pages = '0;
    used_pages  = '0;
    kern_limit  = KERNEL_END_RST;
    low_limit   = LOW_LIMIT_RST;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    plan.push_back(fixed_row(op_row(CMD_ALLOC, '1, '1, 1'b1, '1), ST_OOM, 0, 0, 0));
    plan.push_back(fixed_row(op_row(CMD_RELEASE, 0, 0, 1'b0, 32'h0800_0000),
                             ST_NOCHG, 0, 0, 0));
    plan.push_back(fixed_row(op_row(CMD_RSVD, '1, '1, 1'b1, '1), ST_NOCHG, 0, 0, 0));
    plan.push_back(fixed_row(op_row(CMD_REGION, 32'h0010_0000, 32'h0001_0000, 1'b0, 0),
                             ST_NOCHG, 0, 0, 0));
    plan.push_back(fixed_row(op_row(CMD_REGION, 0, 32'h0010_0000, 1'b1, 0),
                             ST_NOCHG, 0, 0, 0));
    plan.push_back(fixed_row(op_row(CMD_REGION, 32'h0010_0000, 32'h0000_4000, 1'b1, 0),
                             ST_DONE, 0, 32'h4000, 32'h4000));
    plan.push_back(fixed_row(op_row(CMD_ALLOC, 0, 0, 1'b0, 0),
                             ST_DONE, 32'h0010_0000, 32'h4000, 32'h3000));
    plan.push_back(fixed_row(op_row(CMD_RELEASE, 0, 0, 1'b0, 32'h0010_0FFF),
                             ST_DONE, 0, 32'h4000, 32'h4000));
    plan.push_back(fixed_row(op_row(CMD_RELEASE, 0, 0, 1'b0, 32'h0010_0000),
                             ST_NOCHG, 0, 32'h4000, 32'h4000));
    // page never made available: bit cleared, used count goes below zero
    plan.push_back(fixed_row(op_row(CMD_RELEASE, 0, 0, 1'b0, 32'h0000_5000),
                             ST_DONE, 0, 32'h4000, 32'h5000));
    plan.push_back(op_row(CMD_REGION, 32'h0010_0001, 32'h0000_2FFF, 1'b1, 0));
    plan.push_back(op_row(CMD_REGION, 32'hFFFF_F000, 32'h0000_2000, 1'b1, 0));
    plan.push_back(op_row(CMD_REGION, 32'h07FF_C000, 32'h0001_0000, 1'b1, 0));
    plan.push_back(op_row(CMD_ALLOC, 0, 0, 1'b0, 0));
    plan.push_back(op_row(CMD_RELEASE, 0, 0, 1'b0, 32'hFFFF_FFFF));
    plan.push_back(op_row(CMD_REGION, 0, 32'hFFFF_FFFF, 1'b1, 0));
    plan.push_back(cfg_row(REG_KERNEL_END, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(REG_LOW_LIMIT, 32'h0000_0000));
    plan.push_back(op_row(CMD_REGION, 0, 32'h0800_0000, 1'b1, 0));
    plan.push_back(cfg_row(REG_KERNEL_END, 32'h0020_0000));
    plan.push_back(op_row(CMD_REGION, 0, 32'h0040_0000, 1'b1, 0));
    plan.push_back(cfg_row(REG_LOW_LIMIT, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(REG_KERNEL_END, 32'h0000_0000));
    plan.push_back(op_row(CMD_REGION, 0, 32'h0800_0000, 1'b1, 0));
    plan.push_back(cfg_row(REG_LOW_LIMIT, 32'h0000_0000));
    plan.push_back(op_row(CMD_REGION, 0, 32'h0000_3000, 1'b1, 0));
    plan.push_back(op_row(CMD_ALLOC, 0, 0, 1'b0, 0));
    plan.push_back(op_row(CMD_REGION, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 0));
    plan.push_back(op_row(CMD_RELEASE, 0, 0, 1'b0, 32'h07FF_FFFF));

    foreach (plan[n]) begin
      if (plan[n].is_cfg) begin
        settle();
        write_reg(plan[n].reg_idx, plan[n].reg_val);
      end else begin
        send_op(plan[n].op, plan[n].typed, plan[n].rsp);
      end
    end

    for (b = 0; b < RANDOM_BATCHES; b++) begin
      settle();
      case (b)
        0: begin kend_val = KERNEL_END_RST; low_val = LOW_LIMIT_RST; end
        1: begin
          kend_val = $urandom_range(0, 4095) * PAGE_SZ;
          low_val  = $urandom_range(0, 32'h0100_0000);
        end
        2: begin kend_val = 32'hFFFF_FFFF; low_val = 32'h0000_0000; end
        3: begin kend_val = $urandom; low_val = $urandom; end
        4: begin kend_val = 32'h0000_0000; low_val = 32'hFFFF_FFFF; end
        5: begin kend_val = 32'h0000_0000; low_val = 32'h0000_0000; end
        default: begin
          kend_val = $urandom_range(0, 32'h0080_0000);
          low_val  = $urandom_range(0, 32'h0080_0000);
        end
      endcase
      write_reg(REG_KERNEL_END, kend_val);
      write_reg(REG_LOW_LIMIT, low_val);
      repeat (BATCH_WORDS) send_op(random_frame_op(), 1'b0, '0);
    end

    settle();
    if (replies_due.size() != 0)
      report_mismatch("words never returned", replies_due.size(), 0);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // receiver: mixed ready patterns, one long hold-off while words keep coming
  initial begin : reply_sink
    int mode, span, k;
    bit held_off;
    held_off     = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      if (!held_off && replies_seen >= HOLD_AFTER) begin
        held_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) begin
          @(negedge clk_i);
          rsp_ch.ready <= 1'b0;
        end
      end
      mode = $urandom_range(0, 2);
      span = $urandom_range(8, 60);
      for (k = 0; k < span; k++) begin
        @(negedge clk_i);
        case (mode)
          0:       rsp_ch.ready <= 1'b1;
          1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
          default: rsp_ch.ready <= (k % 5 == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : reply_check
    frame_rsp_t want;
    if (rsp_ch.valid && rsp_ch.ready) begin
      replies_seen++;
      if (replies_due.size() == 0) begin
        report_mismatch("unexpected word, status", 32'(rsp_ch.status), 0);
      end else begin
        want = replies_due.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
        if (rsp_ch.page_address !== want.page_address)
          report_mismatch("page_address", rsp_ch.page_address, want.page_address);
        if (rsp_ch.total_bytes !== want.total_bytes)
          report_mismatch("total_bytes", rsp_ch.total_bytes, want.total_bytes);
        if (rsp_ch.free_bytes !== want.free_bytes)
          report_mismatch("free_bytes", rsp_ch.free_bytes, want.free_bytes);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule
